// File: rtl/icp_pkg.sv
package icp_pkg;

  localparam int HEADER_BYTES = 6;
  localparam int LIMIT_W      = 17;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 16;
  localparam int FIFO_DEPTH   = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PAYLOAD = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_VERSION     = 4'd1;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1466;
  localparam logic [7:0]  VERSION_RST     = 8'd1;

  // header byte positions within a datagram
  localparam logic [2:0] HDR_VERSION = 3'd0;
  localparam logic [2:0] HDR_ID_HI   = 3'd1;
  localparam logic [2:0] HDR_ID_LO   = 3'd2;
  localparam logic [2:0] HDR_CHUNK   = 3'd3;
  localparam logic [2:0] HDR_CAMERA  = 3'd4;
  localparam logic [2:0] HDR_TOTAL   = 3'd5;
  localparam logic [2:0] PH_PAYLOAD  = 3'd6;

  typedef struct packed {
    logic [7:0]  payload;
    logic        hdr;
    logic        eod;
    logic        eoi;
    logic [7:0]  version;
    logic [15:0] image_id;
    logic [7:0]  chunk_idx;
    logic [7:0]  camera;
    logic [7:0]  total;
  } icp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } icp_fifo_stat_t;

endpackage

// File: rtl/image_chunk_packetizer.sv
// Path: each byte enters the queue when accepted and leaves by the single output register;
//   the first byte of an image waits for the chunk count, a bit-serial divide by max_payload.
// Throughput: 1 result per cycle while out_ready is high; input runs at 1 byte per cycle, held
//   off during the divide and while the 4-entry queue is full as six header bytes go out.
// Reset: rst_n synchronous, active low; clears image id, counters, queue and output valid,
//   and loads max_payload = 1466, protocol_version = 1.
module image_chunk_packetizer
  import icp_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // payload_byte [7:0], camera_id [15:8], image_length [LENGTH_BITS+15:16], zero fill
  input  logic [((LENGTH_BITS+16+7)/8)*8-1:0] in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_byte [7:0]
  output logic [7:0]                          out_tdata,
  // is_header [0], end_of_image [1]
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [CFG_ADDR_W-1:0]               cfg_addr,
  input  logic [CFG_DATA_W-1:0]               cfg_data
);

  logic [15:0]        max_payload_r;
  logic [7:0]         version_r;
  logic [LIMIT_W-1:0] limit;

  icp_entry_t     q_wdata;
  icp_entry_t     q_head;
  icp_fifo_stat_t q_stat;
  logic           q_push;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
      version_r     <= VERSION_RST;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_MAX_PAYLOAD: max_payload_r <= cfg_data;
        REG_VERSION:     version_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // a register value of zero stands for 65536
  assign limit = (max_payload_r == '0) ? {1'b1, 16'd0} : {1'b0, max_payload_r};

  icp_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata[7:0]),
    .in_camera (in_tdata[15:8]),
    .in_length (in_tdata[LENGTH_BITS+15:16]),
    .limit     (limit),
    .version   (version_r),
    .fifo_full (q_stat.full),
    .push      (q_push),
    .entry     (q_wdata)
  );

  icp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_head),
    .stat  (q_stat)
  );

  icp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .fifo_empty    (q_stat.empty),
    .pop           (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_byte      (out_tdata),
    .out_is_header (out_tuser[0]),
    .out_eod       (out_tlast),
    .out_eoi       (out_tuser[1])
  );

endmodule

// File: rtl/icp_div.sv
module icp_div
  import icp_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [LENGTH_BITS-1:0] dividend,
  input  logic [LIMIT_W-1:0]     divisor,
  output logic                   done,
  output logic [7:0]             quot_lo
);

  localparam int CNT_W = $clog2(LENGTH_BITS);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [LENGTH_BITS-1:0] num_r, num_nxt;
  logic [LIMIT_W-1:0]     div_r, div_nxt;
  logic [LIMIT_W-1:0]     rem_r, rem_nxt;
  logic [7:0]             q_r, q_nxt;
  logic [LIMIT_W:0]       trial;
  logic [LIMIT_W:0]       diff;
  logic                   ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, num_r[LENGTH_BITS-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(LENGTH_BITS - 1);
      num_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[LIMIT_W-1:0] : trial[LIMIT_W-1:0];
      q_nxt   = {q_r[6:0], ge};
      num_nxt = {num_r[LENGTH_BITS-2:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done    = done_r;
  assign quot_lo = q_r;

endmodule

// File: rtl/icp_fifo.sv
module icp_fifo
  import icp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  icp_entry_t     wdata,
  input  logic           pop,
  output icp_entry_t     rdata,
  output icp_fifo_stat_t stat
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  icp_entry_t       mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) begin
      mem[wptr_r] <= wdata;
    end
  end

  assign rdata      = mem[rptr_r];
  assign stat.full  = cnt_r == (PTR_W+1)'(FIFO_DEPTH);
  assign stat.empty = cnt_r == '0;

endmodule

// File: rtl/icp_front.sv
module icp_front
  import icp_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic [7:0]             in_camera,
  input  logic [LENGTH_BITS-1:0] in_length,
  input  logic [LIMIT_W-1:0]     limit,
  input  logic [7:0]             version,
  input  logic                   fifo_full,
  output logic                   push,
  output icp_entry_t             entry
);

  typedef enum logic [2:0] {
    F_RUN  = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t           state_r, state_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [15:0]            bic_r, bic_nxt;
  logic [7:0]             ci_r, ci_nxt;
  logic [15:0]            id_r, id_nxt;
  logic [7:0]             total_r, total_nxt;
  logic [7:0]             cam_r, cam_nxt;
  logic [7:0]             byte_r, byte_nxt;

  logic                   accept;
  logic                   start_img;
  logic                   step;
  logic                   div_done;
  logic [7:0]             quot_lo;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [LIMIT_W-1:0]     bic_inc;
  logic                   eoi;
  logic                   eod;
  logic [7:0]             step_byte;

  icp_div #(.LENGTH_BITS(LENGTH_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_img),
    .dividend (in_length),
    .divisor  (limit),
    .done     (div_done),
    .quot_lo  (quot_lo)
  );

  assign in_ready  = (state_r == F_RUN) && !fifo_full;
  assign accept    = in_valid && in_ready;
  assign start_img = accept && (rem_r == '0) && (in_length != '0);
  assign step      = (accept && (rem_r != '0)) || ((state_r == F_PUSH) && !fifo_full);

  assign rem_dec   = rem_r - 1'b1;
  assign bic_inc   = {1'b0, bic_r} + 1'b1;
  assign eoi       = rem_dec == '0;
  assign eod       = eoi || (bic_inc >= limit);
  assign step_byte = (state_r == F_PUSH) ? byte_r : in_byte;

  always_comb begin
    entry.payload   = step_byte;
    entry.hdr       = bic_r == '0;
    entry.eod       = eod;
    entry.eoi       = eoi;
    entry.version   = version;
    entry.image_id  = id_r;
    entry.chunk_idx = ci_r;
    entry.camera    = cam_r;
    entry.total     = total_r;
  end

  assign push = step;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    bic_nxt   = bic_r;
    ci_nxt    = ci_r;
    id_nxt    = id_r;
    total_nxt = total_r;
    cam_nxt   = cam_r;
    byte_nxt  = byte_r;
    case (state_r)
      F_RUN: begin
        if (start_img) begin
          state_nxt = F_DIV;
          rem_nxt   = in_length;
          bic_nxt   = '0;
          ci_nxt    = '0;
          cam_nxt   = in_camera;
          byte_nxt  = in_byte;
        end
      end
      F_DIV: begin
        if (div_done) begin
          state_nxt = F_PUSH;
          total_nxt = quot_lo + 1'b1;
        end
      end
      F_PUSH: begin
        if (!fifo_full) begin
          state_nxt = F_RUN;
        end
      end
      default: begin
        state_nxt = F_RUN;
      end
    endcase
    if (step) begin
      rem_nxt = rem_dec;
      if (eod) begin
        bic_nxt = '0;
        ci_nxt  = ci_r + 1'b1;
      end else begin
        bic_nxt = bic_inc[15:0];
      end
      if (eoi) begin
        id_nxt = id_r + 1'b1;
        ci_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_RUN;
      rem_r   <= '0;
      bic_r   <= '0;
      ci_r    <= '0;
      id_r    <= '0;
      total_r <= '0;
      cam_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      bic_r   <= bic_nxt;
      ci_r    <= ci_nxt;
      id_r    <= id_nxt;
      total_r <= total_nxt;
      cam_r   <= cam_nxt;
    end
    byte_r <= byte_nxt;
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_full) else $error("push into full queue");
  a_div_to_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_DIV) && div_done |=> state_r == F_PUSH)
    else $error("divider result not taken");
  a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    push && entry.eoi |=> rem_r == '0) else $error("image did not close");
  a_first_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_PUSH) && push |-> entry.hdr && (entry.chunk_idx == '0))
    else $error("first byte of image without header");
`endif

endmodule

// File: rtl/icp_back.sv
module icp_back
  import icp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  icp_entry_t head,
  input  logic       fifo_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_header,
  output logic       out_eod,
  output logic       out_eoi
);

  logic [2:0] phase_r, phase_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       ohdr_r, ohdr_nxt;
  logic       oeod_r, oeod_nxt;
  logic       oeoi_r, oeoi_nxt;
  logic       load;
  logic       hdr_byte;
  logic [7:0] hbyte;

  assign load     = !fifo_empty && (!ovalid_r || out_ready);
  assign hdr_byte = head.hdr && (phase_r != PH_PAYLOAD);
  assign pop      = load && !hdr_byte;

  always_comb begin
    case (phase_r)
      HDR_VERSION: hbyte = head.version;
      HDR_ID_HI:   hbyte = head.image_id[15:8];
      HDR_ID_LO:   hbyte = head.image_id[7:0];
      HDR_CHUNK:   hbyte = head.chunk_idx;
      HDR_CAMERA:  hbyte = head.camera;
      HDR_TOTAL:   hbyte = head.total;
      default:     hbyte = head.payload;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    ovalid_nxt = ovalid_r && !out_ready;
    obyte_nxt  = obyte_r;
    ohdr_nxt   = ohdr_r;
    oeod_nxt   = oeod_r;
    oeoi_nxt   = oeoi_r;
    if (load) begin
      ovalid_nxt = 1'b1;
      if (hdr_byte) begin
        obyte_nxt = hbyte;
        ohdr_nxt  = 1'b1;
        oeod_nxt  = 1'b0;
        oeoi_nxt  = 1'b0;
        phase_nxt = phase_r + 1'b1;
      end else begin
        obyte_nxt = head.payload;
        ohdr_nxt  = 1'b0;
        oeod_nxt  = head.eod;
        oeoi_nxt  = head.eoi;
        phase_nxt = HDR_VERSION;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= HDR_VERSION;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      ovalid_r <= ovalid_nxt;
    end
    obyte_r <= obyte_nxt;
    ohdr_r  <= ohdr_nxt;
    oeod_r  <= oeod_nxt;
    oeoi_r  <= oeoi_nxt;
  end

  assign out_valid     = ovalid_r;
  assign out_byte      = obyte_r;
  assign out_is_header = ohdr_r;
  assign out_eod       = oeod_r;
  assign out_eoi       = oeoi_r;

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_PAYLOAD) else $error("header phase out of range");
  a_hdr_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_header |-> !out_eod && !out_eoi)
    else $error("end mark on header byte");
  a_pop_resets: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> phase_r == HDR_VERSION) else $error("phase not cleared after payload");
`endif

endmodule
